FILE: sv/rpwp_pkg.sv
// Shared types, constants and the character decoder for the radix-prefixed word parser.
// No dependencies; every other file of the block imports this package.
package rpwp_pkg;

	// Digit limits per base and the saturation point of the character counter.
	localparam int unsigned HexLimit = 8;
	localparam int unsigned BinLimit = 32;
	localparam int unsigned DecLimit = 10;
	localparam logic [5:0] COUNT_MAX = 6'd63;
	localparam int unsigned AccWidth = 40;

	// Prefix characters.
	localparam logic [7:0] CHAR_X = 8'h78;
	localparam logic [7:0] CHAR_B = 8'h62;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_BAD_CHAR = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] word_value;
	} result_item_t;

	// Running state of one literal, as seen after the current character.
	typedef struct packed {
		logic [5:0]          count;
		logic [AccWidth-1:0] dec_acc;
		logic [AccWidth-1:0] hex_acc;
		logic [AccWidth-1:0] bin_acc;
		logic [7:0]          second_char;
		logic                bad_any;
		logic                bad_prefixed;
	} acc_state_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} digit_t;

	// Decodes one character into a digit value; non-digits give zero and ok low.
	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t d;
		d.ok = 1'b1;
		d.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.value = 4'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d.value = 4'(c - 8'h41 + 8'd10);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

FILE: sv/rpwp_accum.sv
// Running accumulators and flags of the literal being parsed.
// Depends on rpwp_pkg for the state struct, limits and the digit decoder.
module rpwp_accum import rpwp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  char_item_t item,
	output acc_state_t next_state
);

	acc_state_t state_q;
	digit_t     dig;
	logic [5:0] idx;

	assign idx = state_q.count;
	assign dig = digit_of(item.char_code);

	// Update the flags, and each accumulator whose digit limit is not yet reached, for the incoming character.
	always_comb begin
		next_state = state_q;
		if (idx == 6'd1) begin
			next_state.second_char = item.char_code;
		end
		if (!dig.ok) begin
			next_state.bad_any = 1'b1;
		end
		if (idx < 6'(DecLimit)) begin
			next_state.dec_acc = (state_q.dec_acc << 3) + (state_q.dec_acc << 1)
				+ AccWidth'(dig.value);
		end
		if (idx >= 6'd2) begin
			if (!dig.ok) begin
				next_state.bad_prefixed = 1'b1;
			end
			if (idx < 6'(HexLimit + 2)) begin
				next_state.hex_acc = (state_q.hex_acc << 4) + AccWidth'(dig.value);
			end
			if (idx < 6'(BinLimit + 2)) begin
				next_state.bin_acc = (state_q.bin_acc << 1) + AccWidth'(dig.value);
			end
		end
		next_state.count = (idx < COUNT_MAX) ? idx + 6'd1 : COUNT_MAX;
	end

	// The state is cleared once the final character of a literal is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= item.last_char ? '0 : next_state;
		end
	end

endmodule

FILE: sv/rpwp_select.sv
// Chooses the base of a finished literal and forms its status and value.
// Depends on rpwp_pkg for the state struct, the prefix characters and status codes.
module rpwp_select import rpwp_pkg::*; (
	input  acc_state_t   final_state,
	output result_item_t result
);

	logic                prefixed;
	logic                within_limit;
	logic                bad;
	logic [AccWidth-1:0] acc;

	// A prefix needs more than two characters and an 'x' or 'b' in second place.
	always_comb begin
		prefixed = (final_state.count > 6'd2) &&
			(final_state.second_char == CHAR_X || final_state.second_char == CHAR_B);
		if (prefixed && final_state.second_char == CHAR_X) begin
			within_limit = final_state.count <= 6'(HexLimit + 2);
			acc = final_state.hex_acc;
			bad = final_state.bad_prefixed;
		end else if (prefixed) begin
			within_limit = final_state.count <= 6'(BinLimit + 2);
			acc = final_state.bin_acc;
			bad = final_state.bad_prefixed;
		end else begin
			within_limit = final_state.count <= 6'(DecLimit);
			acc = final_state.dec_acc;
			bad = final_state.bad_any;
		end
	end

	// Errors in order of priority: length, then character, then overflow.
	always_comb begin
		result.word_value = '0;
		if (!within_limit) begin
			result.status = ST_TOO_LONG;
		end else if (bad) begin
			result.status = ST_BAD_CHAR;
		end else if (|acc[AccWidth-1:32]) begin
			result.status = ST_OVERFLOW;
		end else begin
			result.status = ST_OK;
			result.word_value = acc[31:0];
		end
	end

endmodule

FILE: sv/radix_prefixed_word_parser.sv
// Radix-prefixed word parser: one character per transfer, one result per literal.
// A literal's last character passes the input register, then its result is held in the result register.
// Throughput: one character per cycle, unless a literal's last character waits for a full result register.
// Reset: arst_n clears the accumulators and the valid flags of the input and result stages.
// Depends on rpwp_pkg, rpwp_accum and rpwp_select.
module radix_prefixed_word_parser import rpwp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         char_valid,
	output logic         char_stall,
	input  char_item_t   char_data,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_data
);

	char_item_t   item_s1;
	logic         valid_s1;
	result_item_t result_q;
	logic         result_valid_q;
	logic         out_free;
	logic         advance;
	logic         accept;
	acc_state_t   next_state;
	result_item_t result_next;

	// A character leaves the input stage unless it ends a literal whose result cannot be stored.
	assign out_free   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && (!item_s1.last_char || out_free);
	assign char_stall = valid_s1 && !advance;
	assign accept     = char_valid && !char_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= char_data;
		end
	end

	rpwp_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.next_state (next_state)
	);

	rpwp_select u_select (
		.final_state (next_state),
		.result      (result_next)
	);

	// Result register; it is refilled in the cycle its previous result transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last_char) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_char) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

FILE: bench/radix_prefixed_word_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for radix_prefixed_word_parser: a directed table, then random literals.
// Results are scored against a behavioural parser written here; depends on rpwp_pkg and the RTL.
module radix_prefixed_word_parser_tb;
	import rpwp_pkg::*;

	localparam int unsigned DirRows     = 29;
	localparam int unsigned RandomItems = 750;
	localparam int unsigned TailItems   = 100;
	localparam int unsigned HoldCycles  = 300;
	localparam int unsigned DrainCycles = 8;

	// One row of stimulus: the character transfer and, optionally, a hand-written result.
	typedef struct packed {
		char_item_t   item;
		logic         typed;
		result_item_t typed_res;
	} stim_row_t;

	// Running state of the behavioural parser for the literal in progress.
	typedef struct packed {
		logic [5:0]          count;
		logic [AccWidth-1:0] dec_sum;
		logic [AccWidth-1:0] hex_sum;
		logic [AccWidth-1:0] bin_sum;
		logic [7:0]          second;
		logic                bad_any;
		logic                bad_tail;
	} scan_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         char_valid = 1'b0;
	logic         char_stall;
	char_item_t   char_data = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_data;

	stim_row_t    stim_q[$];
	result_item_t expected_words[$];
	scan_t        scan = '0;
	int unsigned  offered = 0;
	int unsigned  chars_taken = 0;
	int unsigned  failures = 0;
	int unsigned  src_gap = 0;
	int unsigned  sink_hold = 0;
	bit           src_bursty = 1'b1;
	bit           sink_bursty = 1'b1;
	logic         quiet_tail = 1'b0;
	logic         long_hold = 1'b0;
	stim_row_t    taken_row;
	logic         word_done;
	result_item_t predicted;
	result_item_t want;

	// Directed literals, one character per row; the final row of each carries its result.
	stim_row_t directed_rows [DirRows] = '{
		// Non-digit first character before an 'x' prefix is not read: hex F.
		{8'hFF, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h78, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h46, 1'b1, 1'b1, ST_OK, 32'd15},
		// Binary prefix with a digit that the base does not allow: counts as 2.
		{8'h7A, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h62, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h32, 1'b1, 1'b1, ST_OK, 32'd2},
		// Two characters only, so no prefix: read as decimal, both bad.
		{8'h00, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h78, 1'b1, 1'b1, ST_BAD_CHAR, 32'd0},
		// Ten nines exceed 32 bits.
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b1, 1'b1, ST_OVERFLOW, 32'd0},
		// Eleven decimal characters with a bad one inside: length wins.
		{8'h31, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h32, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h33, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h34, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h7A, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h36, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h37, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h38, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h39, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h30, 1'b0, 1'b0, ST_OK, 32'd0},
		{8'h31, 1'b1, 1'b1, ST_TOO_LONG, 32'd0}
	};

	radix_prefixed_word_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_data    (char_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// Maps a character to its digit value in any base; returns low for a non-digit.
	function automatic logic char_digit(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
			return 1'b1;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
			return 1'b1;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Picks one of the 22 digit characters, lower and upper case alike.
	function automatic logic [7:0] rand_digit_char();
		int unsigned k;
		k = $urandom_range(0, 21);
		if (k < 10)
			return 8'(8'h30 + k);
		if (k < 16)
			return 8'(8'h61 + k - 10);
		return 8'(8'h41 + k - 16);
	endfunction

	// Behavioural parser: folds one character into the running sums and, on the final
	// character, chooses the base and works out the status and the word.
	task automatic parse_char(input char_item_t it, output logic done, output result_item_t res);
		int unsigned idx;
		int unsigned n;
		logic [3:0] v;
		logic is_digit;
		logic prefixed;
		logic fits;
		logic bad;
		logic [AccWidth-1:0] acc;
		idx = scan.count;
		is_digit = char_digit(it.char_code, v);
		if (idx == 1)
			scan.second = it.char_code;
		if (!is_digit)
			scan.bad_any = 1'b1;
		if (idx < DecLimit)
			scan.dec_sum = scan.dec_sum * 10 + v;
		if (idx >= 2) begin
			if (!is_digit)
				scan.bad_tail = 1'b1;
			if (idx - 2 < HexLimit)
				scan.hex_sum = scan.hex_sum * 16 + v;
			if (idx - 2 < BinLimit)
				scan.bin_sum = scan.bin_sum * 2 + v;
		end
		n = (idx < COUNT_MAX) ? idx + 1 : COUNT_MAX;
		scan.count = 6'(n);
		done = it.last_char;
		res = '0;
		if (!it.last_char)
			return;

		// Base selection happens only once the length is known.
		prefixed = n > 2 && (scan.second == CHAR_X || scan.second == CHAR_B);
		if (prefixed && scan.second == CHAR_X) begin
			fits = (n - 2) <= HexLimit;
			acc = scan.hex_sum;
			bad = scan.bad_tail;
		end else if (prefixed) begin
			fits = (n - 2) <= BinLimit;
			acc = scan.bin_sum;
			bad = scan.bad_tail;
		end else begin
			fits = n <= DecLimit;
			acc = scan.dec_sum;
			bad = scan.bad_any;
		end
		if (!fits) begin
			res.status = ST_TOO_LONG;
		end else if (bad) begin
			res.status = ST_BAD_CHAR;
		end else if (acc[AccWidth-1:32] != '0) begin
			res.status = ST_OVERFLOW;
		end else begin
			res.status = ST_OK;
			res.word_value = acc[31:0];
		end
		scan = '0;
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	// Character sender: offers rows in order, with random bursts of idle cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!char_valid || !char_stall) begin
				if (src_gap > 0) begin
					src_gap--;
					char_valid <= 1'b0;
				end else if (offered < stim_q.size()) begin
					char_valid <= 1'b1;
					char_data <= stim_q[offered].item;
					offered++;
					if ($urandom_range(0, 39) == 0)
						src_bursty = !src_bursty;
					if (src_bursty && !quiet_tail && $urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 10);
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: stalls in random bursts, and for the long hold-off below.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sink_hold > 0)
				sink_hold--;
			else if (sink_bursty && !quiet_tail && $urandom_range(0, 4) == 0)
				sink_hold = $urandom_range(1, 10);
			if ($urandom_range(0, 49) == 0)
				sink_bursty = !sink_bursty;
			result_stall <= long_hold || (sink_hold > 0);
		end
	end

	// Long hold-off on the result side so that the block fills and stalls its input.
	initial begin
		wait (chars_taken >= 150);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Scoreboard: predicts on each character transfer and checks each result transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				taken_row = stim_q[chars_taken];
				chars_taken++;
				parse_char(taken_row.item, word_done, predicted);
				if (word_done)
					expected_words.push_back(taken_row.typed ? taken_row.typed_res : predicted);
			end
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result with none expected: status %0d word %h",
						$time, result_data.status, result_data.word_value);
					failures++;
				end else begin
					want = expected_words.pop_front();
					if (result_data.status !== want.status) begin
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, result_data.status);
						failures++;
					end
					if (result_data.word_value !== want.word_value) begin
						$display("%0t: word_value expected %h, actual %h",
							$time, want.word_value, result_data.word_value);
						failures++;
					end
				end
			end
			quiet_tail <= (chars_taken + TailItems >= stim_q.size());
		end
	end

	// Stimulus build, reset, drain and verdict.
	initial begin
		logic [7:0] lit[$];
		stim_row_t row;
		int unsigned pick;
		int unsigned len;

		foreach (directed_rows[i])
			stim_q.push_back(directed_rows[i]);

		// Random literals: mostly well-formed in each base, then broken ones and noise.
		while (stim_q.size() < DirRows + RandomItems) begin
			lit.delete();
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				if ($urandom_range(0, 2) == 0) begin
					// Ten digits starting with 4 straddle the 32-bit limit.
					lit.push_back(8'h34);
					repeat (9) lit.push_back(8'(8'h30 + $urandom_range(0, 9)));
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 12)
						: $urandom_range(1, 10);
					repeat (len) lit.push_back(rand_digit_char());
				end
			end else if (pick < 55) begin
				lit.push_back($urandom_range(0, 1) ? 8'h30 : 8'($urandom_range(0, 255)));
				lit.push_back(CHAR_X);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10)
					: $urandom_range(0, 8);
				repeat (len) lit.push_back(rand_digit_char());
			end else if (pick < 80) begin
				lit.push_back($urandom_range(0, 1) ? 8'h30 : 8'($urandom_range(0, 255)));
				lit.push_back(CHAR_B);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 34)
					: $urandom_range(1, 32);
				repeat (len)
					lit.push_back(($urandom_range(0, 9) == 0) ? rand_digit_char()
						: 8'(8'h30 + $urandom_range(0, 1)));
			end else if (pick < 88) begin
				// A well-formed literal with one character overwritten by any byte.
				len = $urandom_range(1, 10);
				if ($urandom_range(0, 1)) begin
					lit.push_back(8'h30);
					lit.push_back(CHAR_X);
					len = $urandom_range(1, 8);
				end
				repeat (len) lit.push_back(rand_digit_char());
				lit[$urandom_range(0, lit.size() - 1)] = 8'($urandom_range(0, 255));
			end else if (pick < 93) begin
				// Long enough to pass every length limit, and at times to saturate the character count.
				len = $urandom_range(40, 70);
				repeat (len) lit.push_back(rand_digit_char());
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) lit.push_back(8'($urandom_range(0, 255)));
			end
			foreach (lit[i]) begin
				row.item.char_code = lit[i];
				row.item.last_char = (i == lit.size() - 1);
				row.typed = 1'b0;
				row.typed_res = '0;
				stim_q.push_back(row);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (chars_taken < stim_q.size() || expected_words.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (failures == 0)
			$display("radix_prefixed_word_parser: match");
		else
			$display("radix_prefixed_word_parser: mismatch");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin
		#200000;
		$display("radix_prefixed_word_parser: mismatch");
		$finish;
	end

endmodule
